// File: sv/hrtf_pkg.sv
// Shared types, codes and helper functions of the H.265 RTP temporal layer filter.
package hrtf_pkg;

    localparam logic [11:0] MAX_PAYLOAD = 12'd4095;

    typedef enum logic [2:0] {
        V_OK          = 3'd0,
        V_EMPTY       = 3'd1,
        V_ABOVE_LAYER = 3'd2,
        V_BAD_HEADER  = 3'd3,
        V_CONTROL     = 3'd4,
        V_BAD_AGGR    = 3'd5,
        V_SHORT_FRAG  = 3'd6,
        V_NO_INTRA    = 3'd7
    } t_verdict;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_AGGR   = 2'd1,
        KIND_FRAG   = 2'd2,
        KIND_CTRL   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_SIZE_HI   = 3'd0,
        PH_SIZE_LO   = 3'd1,
        PH_UNIT_HDR  = 3'd2,
        PH_UNIT_DATA = 3'd3,
        PH_DONE      = 3'd4
    } t_aggr_phase;

    localparam logic [5:0] TYPE_AGGR     = 6'd48;
    localparam logic [5:0] TYPE_FRAG     = 6'd49;
    localparam logic [5:0] TYPE_CTRL_LO  = 6'd35;
    localparam logic [5:0] TYPE_CTRL_HI  = 6'd38;

    typedef struct packed {
        logic       marker;
        logic [2:0] tid;
        logic       bsync;
        logic       indep;
        logic       sof;
        logic       has_marks;
    } t_sideband;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic [11:0] packet_length;
        t_sideband   sideband;
    } t_in_item;

    // Parser status after the current byte.
    typedef struct packed {
        logic [11:0] total;
        logic [11:0] bytes_left;
        t_kind       kind;
        logic        seen_intra;
        t_verdict    error_code;
    } t_parse_stat;

    function automatic logic type_is_intra(input logic [5:0] t);
        type_is_intra = ((t >= 6'd16) && (t <= 6'd23)) || ((t >= 6'd32) && (t <= 6'd34));
    endfunction

    function automatic t_kind classify(input logic [5:0] t);
        if (t == TYPE_AGGR) begin
            classify = KIND_AGGR;
        end else if (t == TYPE_FRAG) begin
            classify = KIND_FRAG;
        end else if ((t >= TYPE_CTRL_LO) && (t <= TYPE_CTRL_HI)) begin
            classify = KIND_CTRL;
        end else begin
            classify = KIND_SINGLE;
        end
    endfunction

endpackage

// File: sv/hevc_rtp_temporal_layer_filter_core.sv
// Top level of the H.265 RTP temporal layer filter: input stage, decision, result register.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_stall       one payload byte plus packet sideband
//  result    out        o_out_valid / i_out_stall     forward, marker, verdict, active layer
//  config    in         APB psel/penable/pwrite       target temporal layer at address 0
//
// Flow: one transaction per cycle while no held result stalls the input; the last byte
//   of a packet passes the input register, then the result register, before its result is valid.
// The only loop is the per-byte parser state update, one byte per cycle unless the input stalls.
// Stalls: a held result blocks only an item in the input register that closes a packet;
//   payload bytes that close nothing keep flowing.
// Reset: synchronous, active low; clears the layer, the target and all handshakes, and arms the intra wait.
module hevc_rtp_temporal_layer_filter_core
    import hrtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_of_packet,
    input  logic        i_last_of_packet,
    input  logic [11:0] i_packet_length,
    input  logic        i_has_frame_marks,
    input  logic        i_mark_start_of_frame,
    input  logic        i_mark_independent,
    input  logic        i_mark_base_sync,
    input  logic [2:0]  i_mark_temporal_id,
    input  logic        i_rtp_marker,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_forward,
    output logic        o_marker_out,
    output logic [2:0]  o_verdict,
    output logic [2:0]  o_active_layer_out,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration register.
    logic [2:0] r_target;

    // Input register.
    logic       r_in_valid;
    t_in_item   r_in;

    // Packet and stream state.
    logic       r_open;
    logic       n_open;
    t_sideband  r_held;
    logic [2:0] r_active;
    logic [2:0] n_active;
    logic       r_awaiting;
    logic       n_awaiting;

    // Result register.
    logic       r_out_valid;
    logic       r_forward;
    logic       r_marker;
    t_verdict   r_verdict;
    logic [2:0] r_layer;

    logic        w_in_fire;
    logic        w_open_eff;
    logic        w_closes;
    logic        w_out_hold;
    logic        w_proc;
    logic        w_step;
    logic        w_res_fire;
    logic [11:0] w_len_sat;
    t_sideband   w_sb;
    t_parse_stat w_stat;
    t_verdict    w_verdict;
    logic        w_intra;
    logic [2:0]  w_cur;
    logic        w_cfg_wr;

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {29'd0, r_target} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 3'd0;
        end else if (w_cfg_wr) begin
            r_target <= pwdata[2:0];
        end
    end

    // ---------------- input stage ----------------
    // The item in the input register is processed unless it closes a packet
    // while the result register is still held.
    assign w_open_eff = r_in.first || r_open;
    assign w_closes   = w_open_eff && r_in.last;
    assign w_out_hold = r_out_valid && i_out_stall;
    assign w_proc     = r_in_valid && !(w_closes && w_out_hold);
    assign w_step     = w_proc && w_open_eff;
    assign w_res_fire = w_proc && w_closes;
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in.data_byte          <= i_data_byte;
            r_in.first              <= i_first_of_packet;
            r_in.last               <= i_last_of_packet;
            r_in.packet_length      <= i_packet_length;
            r_in.sideband.has_marks <= i_has_frame_marks;
            r_in.sideband.sof       <= i_mark_start_of_frame;
            r_in.sideband.indep     <= i_mark_independent;
            r_in.sideband.bsync     <= i_mark_base_sync;
            r_in.sideband.tid       <= i_mark_temporal_id;
            r_in.sideband.marker    <= i_rtp_marker;
        end
    end

    // Clamp the declared length to the payload limit.
    assign w_len_sat = (r_in.packet_length > MAX_PAYLOAD) ? MAX_PAYLOAD : r_in.packet_length;

    hrtf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_first (r_in.first),
        .i_len   (w_len_sat),
        .i_byte  (r_in.data_byte),
        .o_stat  (w_stat)
    );

    // Sideband is sampled on the first item and held for the packet.
    assign w_sb = r_in.first ? r_in.sideband : r_held;

    // ---------------- packet decision ----------------
    always_comb begin
        n_active   = r_active;
        n_awaiting = r_awaiting;
        w_verdict  = V_OK;
        w_intra    = 1'b0;
        w_cur      = r_active;
        if (w_stat.total == 12'd0) begin
            w_verdict = V_EMPTY;
        end else if (w_sb.has_marks) begin
            // Frame marks: move the layer up on a base-sync start of frame,
            // drop back to the target on a marked packet.
            w_intra = w_sb.sof && w_sb.indep;
            if (r_target > r_active) begin
                if (w_sb.bsync && w_sb.sof && (w_sb.tid > r_active) &&
                    (w_sb.tid <= r_target)) begin
                    n_active = w_sb.tid;
                    w_cur    = w_sb.tid;
                end
            end else if (r_target < r_active) begin
                if (w_sb.marker) begin
                    n_active = r_target;
                end
            end
            if (w_cur < w_sb.tid) begin
                w_verdict = V_ABOVE_LAYER;
            end
        end else begin
            if ((w_stat.bytes_left != 12'd0) || (w_stat.total < 12'd2)) begin
                w_verdict = V_BAD_HEADER;
            end else if (w_stat.kind == KIND_CTRL) begin
                w_verdict = V_CONTROL;
            end else if ((w_stat.kind == KIND_FRAG) && (w_stat.total < 12'd3)) begin
                w_verdict = V_SHORT_FRAG;
            end else if ((w_stat.kind == KIND_AGGR) && (w_stat.error_code != V_OK)) begin
                w_verdict = w_stat.error_code;
            end
            w_intra = w_stat.seen_intra;
        end
        // Hold everything back until the first intra packet.
        if ((w_verdict == V_OK) && r_awaiting) begin
            if (!w_intra) begin
                w_verdict = V_NO_INTRA;
            end else begin
                n_awaiting = 1'b0;
            end
        end
    end

    // Advance the open-packet flag: open on first, close on last.
    assign n_open = w_proc ? (w_open_eff && !r_in.last) : r_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_active   <= 3'd0;
            r_awaiting <= 1'b1;
        end else begin
            r_open <= n_open;
            if (w_res_fire) begin
                r_active   <= n_active;
                r_awaiting <= n_awaiting;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in.first) begin
            r_held <= r_in.sideband;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_fire) begin
            r_forward <= (w_verdict == V_OK);
            r_marker  <= (w_verdict == V_OK) && w_sb.marker;
            r_verdict <= w_verdict;
            r_layer   <= n_active;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_forward          = r_forward;
    assign o_marker_out       = r_marker;
    assign o_verdict          = r_verdict;
    assign o_active_layer_out = r_layer;

`ifndef SYNTHESIS
    // A marker is only passed on a forwarded packet.
    a_marker_needs_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_marker_out) |-> o_forward)
        else $error("marker out on a dropped packet");

    // A closing item must wait while the result register is held.
    a_close_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_closes && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("closing item taken while result held");

    // The active layer moves only when a packet closes.
    a_layer_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_res_fire |=> $stable(r_active))
        else $error("active layer changed without a result");

    // Once an intra packet has passed, the wait never comes back.
    a_intra_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_awaiting |=> !r_awaiting)
        else $error("intra wait set again");
`endif

endmodule

// File: sv/hrtf_parse.sv
// Payload byte parser: unit type, fragment and aggregation walk, length errors.
module hrtf_parse
    import hrtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_first,
    input  logic [11:0] i_len,
    input  logic [7:0]  i_byte,
    output t_parse_stat o_stat
);

    logic [1:0]  r_pos,   n_pos,   e_pos;
    logic [11:0] r_total, n_total, e_total;
    logic [11:0] r_left,  n_left,  e_left;
    t_kind       r_kind,  n_kind,  e_kind;
    logic        r_seen,  n_seen,  e_seen;
    t_verdict    r_err,   n_err,   e_err;
    logic [11:0] r_usize, n_usize, e_usize;
    logic [7:0]  r_shi,   n_shi,   e_shi;
    t_aggr_phase r_phase, n_phase, e_phase;

    logic        w_eat;
    logic        w_aggr_on;
    logic [15:0] w_size;
    logic [15:0] w_rem_m1;
    logic        w_size_bad;
    logic        w_size_one;
    logic [11:0] w_usize_dec;
    logic [5:0]  w_hdr_type;

    // Start fresh on the first item of a packet.
    always_comb begin
        if (i_first) begin
            e_pos   = 2'd0;
            e_total = i_len;
            e_left  = i_len;
            e_kind  = KIND_SINGLE;
            e_seen  = 1'b0;
            e_err   = V_OK;
            e_usize = 12'd0;
            e_shi   = 8'd0;
            e_phase = PH_SIZE_HI;
        end else begin
            e_pos   = r_pos;
            e_total = r_total;
            e_left  = r_left;
            e_kind  = r_kind;
            e_seen  = r_seen;
            e_err   = r_err;
            e_usize = r_usize;
            e_shi   = r_shi;
            e_phase = r_phase;
        end
    end

    assign w_eat       = (e_left != 12'd0);
    assign w_aggr_on   = (e_kind == KIND_AGGR) && e_pos[1] && (e_err == V_OK);
    assign w_size      = {e_shi, i_byte};
    assign w_rem_m1    = {4'd0, e_left - 12'd1};
    assign w_size_bad  = (w_size == 16'd0) || (w_size > w_rem_m1);
    assign w_size_one  = (w_size == 16'd1);
    assign w_usize_dec = e_usize - 12'd1;
    assign w_hdr_type  = i_byte[6:1];

    // Aggregation walk: next phase.
    always_comb begin
        n_phase = e_phase;
        if (w_eat && w_aggr_on) begin
            unique case (e_phase)
                PH_SIZE_HI: begin
                    n_phase = (e_left > 12'd2) ? PH_SIZE_LO : PH_DONE;
                end
                PH_SIZE_LO: begin
                    if (!w_size_bad && !w_size_one) begin
                        n_phase = PH_UNIT_HDR;
                    end
                end
                PH_UNIT_HDR, PH_UNIT_DATA: begin
                    n_phase = (w_usize_dec == 12'd0) ? PH_SIZE_HI : PH_UNIT_DATA;
                end
                default: n_phase = e_phase;
            endcase
        end
    end

    // Byte effects on the packet state.
    always_comb begin
        n_pos   = e_pos;
        n_total = e_total;
        n_left  = e_left;
        n_kind  = e_kind;
        n_seen  = e_seen;
        n_err   = e_err;
        n_usize = e_usize;
        n_shi   = e_shi;
        if (w_eat) begin
            n_pos  = (e_pos == 2'd3) ? e_pos : e_pos + 2'd1;
            n_left = e_left - 12'd1;
            if (e_pos == 2'd0) begin
                n_kind = classify(w_hdr_type);
                if ((classify(w_hdr_type) == KIND_SINGLE) && type_is_intra(w_hdr_type)) begin
                    n_seen = 1'b1;
                end
            end else if ((e_kind == KIND_FRAG) && (e_pos == 2'd2)) begin
                if (i_byte[7] && type_is_intra(i_byte[5:0])) begin
                    n_seen = 1'b1;
                end
            end else if (w_aggr_on) begin
                case (e_phase)
                    PH_SIZE_HI: begin
                        if (e_left > 12'd2) begin
                            n_shi = i_byte;
                        end
                    end
                    PH_SIZE_LO: begin
                        if (w_size_bad) begin
                            n_err = V_BAD_AGGR;
                        end else if (w_size_one) begin
                            n_err = V_BAD_HEADER;
                        end else begin
                            n_usize = w_size[11:0];
                        end
                    end
                    PH_UNIT_HDR: begin
                        if (type_is_intra(w_hdr_type)) begin
                            n_seen = 1'b1;
                        end
                        n_usize = w_usize_dec;
                    end
                    PH_UNIT_DATA: begin
                        n_usize = w_usize_dec;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_total <= 12'd0;
            r_left  <= 12'd0;
            r_kind  <= KIND_SINGLE;
            r_seen  <= 1'b0;
            r_err   <= V_OK;
            r_phase <= PH_SIZE_HI;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_total <= n_total;
            r_left  <= n_left;
            r_kind  <= n_kind;
            r_seen  <= n_seen;
            r_err   <= n_err;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_usize <= n_usize;
            r_shi   <= n_shi;
        end
    end

    assign o_stat = '{total:      n_total,
                      bytes_left: n_left,
                      kind:       n_kind,
                      seen_intra: n_seen,
                      error_code: n_err};

endmodule

// File: bench/tb_top.sv
// Self-checking testbench of the H.265 RTP temporal layer filter core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hrtf_pkg::*;

    // Byte address of the target temporal layer register.
    localparam logic [2:0] ADDR_TARGET = 3'd0;

    // Target settings walked through after the directed part; 7 -> 0 forces the layer down.
    localparam logic [2:0] TARGET_PLAN [11] = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1,
                                               3'd6, 3'd2, 3'd4, 3'd0, 3'd7};
    localparam int PHASE_ITEMS = 160;

    // One packet decision as seen on the result channel.
    typedef struct packed {
        logic       fwd;
        logic       mk;
        t_verdict   verdict;
        logic [2:0] layer;
    } t_outcome;

    // Tracks filter state per accepted byte and holds the decisions still owed by the block.
    class verdict_board;
        logic [2:0]  target;
        logic        awaiting;
        logic [2:0]  active;
        logic [11:0] byte_idx;
        logic [11:0] left;
        t_kind       kind;
        logic [5:0]  utype;
        logic [15:0] unit_left;
        logic [7:0]  size_hi;
        logic        seen;
        t_verdict    err;
        t_sideband   side;
        logic        open;
        t_aggr_phase phase;
        t_outcome    pending_verdicts[$];
        int          errors;

        function new();
            target    = 3'd0;
            awaiting  = 1'b1;
            active    = 3'd0;
            byte_idx  = '0;
            left      = '0;
            kind      = KIND_SINGLE;
            utype     = '0;
            unit_left = '0;
            size_hi   = '0;
            seen      = 1'b0;
            err       = V_OK;
            side      = '0;
            open      = 1'b0;
            phase     = PH_SIZE_HI;
            errors    = 0;
        endfunction

        function void set_target(input logic [2:0] val);
            target = val;
        endfunction

        function bit intra_nal(input logic [5:0] t);
            return (t >= 6'd16 && t <= 6'd23) || (t >= 6'd32 && t <= 6'd34);
        endfunction

        function void parse_byte(input logic [7:0] b);
            int unsigned pos;
            int unsigned rem;
            int unsigned size;
            pos = byte_idx;
            rem = left;
            if (pos == 0) begin
                utype = b[6:1];
                if (utype == TYPE_AGGR) begin
                    kind = KIND_AGGR;
                end else if (utype == TYPE_FRAG) begin
                    kind = KIND_FRAG;
                end else if (utype >= TYPE_CTRL_LO && utype <= TYPE_CTRL_HI) begin
                    kind = KIND_CTRL;
                end else begin
                    kind = KIND_SINGLE;
                end
                if (kind == KIND_SINGLE && intra_nal(utype)) seen = 1'b1;
            end else if (kind == KIND_FRAG && pos == 2) begin
                if (b[7] && intra_nal(b[5:0])) seen = 1'b1;
            end else if (kind == KIND_AGGR && pos >= 2 && err == V_OK) begin
                case (phase)
                    PH_SIZE_HI: begin
                        if (rem > 2) begin
                            size_hi = b;
                            phase   = PH_SIZE_LO;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    PH_SIZE_LO: begin
                        size = {size_hi, b};
                        if (size == 0 || size > rem - 1) begin
                            err = V_BAD_AGGR;
                        end else if (size < 2) begin
                            err = V_BAD_HEADER;
                        end else begin
                            unit_left = size[15:0];
                            phase     = PH_UNIT_HDR;
                        end
                    end
                    PH_UNIT_HDR: begin
                        if (intra_nal(b[6:1])) seen = 1'b1;
                        unit_left = unit_left - 16'd1;
                        if (unit_left == 0) begin
                            phase = PH_SIZE_HI;
                        end else begin
                            phase = PH_UNIT_DATA;
                        end
                    end
                    PH_UNIT_DATA: begin
                        unit_left = unit_left - 16'd1;
                        if (unit_left == 0) phase = PH_SIZE_HI;
                    end
                    default: ;
                endcase
            end
            byte_idx = byte_idx + 12'd1;
            left     = left - 12'd1;
        endfunction

        function t_outcome judge_packet();
            int unsigned total;
            t_verdict    v;
            bit          intra;
            logic [2:0]  cur;
            t_outcome    res;
            total = byte_idx + left;
            v     = V_OK;
            intra = 1'b0;
            if (total == 0) begin
                v = V_EMPTY;
            end else if (side.has_marks) begin
                intra = side.sof && side.indep;
                cur   = active;
                if (target > active) begin
                    if (side.bsync && side.sof && side.tid > cur && side.tid <= target) begin
                        active = side.tid;
                        cur    = side.tid;
                    end
                end else if (target < active) begin
                    if (side.marker) active = target;
                end
                if (cur < side.tid) v = V_ABOVE_LAYER;
            end else begin
                if (left != 0 || total < 2) begin
                    v = V_BAD_HEADER;
                end else if (kind == KIND_CTRL) begin
                    v = V_CONTROL;
                end else if (kind == KIND_FRAG && total < 3) begin
                    v = V_SHORT_FRAG;
                end else if (kind == KIND_AGGR && err != V_OK) begin
                    v = err;
                end
                intra = seen;
            end
            if (v == V_OK && awaiting) begin
                if (!intra) begin
                    v = V_NO_INTRA;
                end else begin
                    awaiting = 1'b0;
                end
            end
            res.fwd     = (v == V_OK);
            res.mk      = (v == V_OK) ? side.marker : 1'b0;
            res.verdict = v;
            res.layer   = active;
            return res;
        endfunction

        function void note_item(input t_in_item it);
            if (it.first) begin
                open      = 1'b1;
                byte_idx  = '0;
                left      = it.packet_length;
                kind      = KIND_SINGLE;
                utype     = '0;
                unit_left = '0;
                size_hi   = '0;
                seen      = 1'b0;
                err       = V_OK;
                phase     = PH_SIZE_HI;
                side      = it.sideband;
            end
            if (!open) return;
            if (left != 0) parse_byte(it.data_byte);
            if (it.last) begin
                pending_verdicts.push_back(judge_packet());
                open = 1'b0;
            end
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(input t_outcome got);
            t_outcome want;
            if (pending_verdicts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got fwd=%0d verdict=%0d",
                         $time, got.fwd, got.verdict);
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("forward", want.fwd, got.fwd);
            compare_field("marker_out", want.mk, got.mk);
            compare_field("verdict", want.verdict, got.verdict);
            compare_field("active_layer_out", want.layer, got.layer);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_first_of_packet;
    logic        i_last_of_packet;
    logic [11:0] i_packet_length;
    logic        i_has_frame_marks;
    logic        i_mark_start_of_frame;
    logic        i_mark_independent;
    logic        i_mark_base_sync;
    logic [2:0]  i_mark_temporal_id;
    logic        i_rtp_marker;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_forward;
    logic        o_marker_out;
    logic [2:0]  o_verdict;
    logic [2:0]  o_active_layer_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    verdict_board board;
    logic [7:0]   body[$];      // payload bytes of the packet being built
    int           items_sent;   // transactions that belong to a packet
    bit           steady;       // suppress idle cycles on both sides

    hevc_rtp_temporal_layer_filter_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_data_byte           (i_data_byte),
        .i_first_of_packet     (i_first_of_packet),
        .i_last_of_packet      (i_last_of_packet),
        .i_packet_length       (i_packet_length),
        .i_has_frame_marks     (i_has_frame_marks),
        .i_mark_start_of_frame (i_mark_start_of_frame),
        .i_mark_independent    (i_mark_independent),
        .i_mark_base_sync      (i_mark_base_sync),
        .i_mark_temporal_id    (i_mark_temporal_id),
        .i_rtp_marker          (i_rtp_marker),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_forward             (o_forward),
        .o_marker_out          (o_marker_out),
        .o_verdict             (o_verdict),
        .o_active_layer_out    (o_active_layer_out),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Pick a unit type, intra when asked, else anything in the 6-bit range.
    function automatic logic [5:0] pick_type(input bit want_intra);
        int r;
        if (!want_intra) return 6'($urandom_range(0, 63));
        r = $urandom_range(0, 10);
        return (r < 8) ? 6'(16 + r) : 6'(32 + r - 8);
    endfunction

    // Sideband without frame marks; only the RTP marker matters then.
    function automatic t_sideband unmarked();
        t_sideband sb;
        sb = t_sideband'(8'($urandom_range(0, 255)));
        sb.has_marks = 1'b0;
        return sb;
    endfunction

    // Fully random transaction outside the first item; sampled fields are don't-care here.
    function automatic t_in_item scrap_item();
        t_in_item it;
        it.data_byte     = 8'($urandom_range(0, 255));
        it.first         = 1'b0;
        it.last          = 1'($urandom_range(0, 1));
        it.packet_length = 12'($urandom_range(0, 4095));
        it.sideband      = t_sideband'(8'($urandom_range(0, 255)));
        return it;
    endfunction

    // Present one transaction at the falling edge, hold it until accepted.
    task automatic offer_item(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data_byte           = it.data_byte;
        i_first_of_packet     = it.first;
        i_last_of_packet      = it.last;
        i_packet_length       = it.packet_length;
        i_has_frame_marks     = it.sideband.has_marks;
        i_mark_start_of_frame = it.sideband.sof;
        i_mark_independent    = it.sideband.indep;
        i_mark_base_sync      = it.sideband.bsync;
        i_mark_temporal_id    = it.sideband.tid;
        i_rtp_marker          = it.sideband.marker;
        i_in_valid            = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    // Send count transactions as one packet; bytes beyond body are random.
    // Leave the packet open when closes is 0.
    task automatic emit_packet(input t_sideband sb, input logic [11:0] len, input int count,
                               input bit closes);
        t_in_item it;
        for (int k = 0; k < count; k++) begin
            it = scrap_item();
            if (k < body.size()) it.data_byte = body[k];
            it.first = (k == 0);
            it.last  = closes && (k == count - 1);
            if (k == 0) begin
                it.packet_length = len;
                it.sideband      = sb;
            end
            offer_item(it);
            items_sent++;
        end
        body.delete();
    endtask

    // Frame-marked packet: bytes are ignored, so keep the transaction count low.
    task automatic marked_packet();
        t_sideband   sb;
        logic [11:0] len;
        int          count;
        sb           = t_sideband'(8'($urandom_range(0, 255)));
        sb.has_marks = 1'b1;
        sb.sof       = chance(75);
        sb.bsync     = chance(50);
        sb.indep     = chance(40);
        sb.marker    = chance(35);
        len   = chance(15) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 8));
        count = (len == 0) ? 1 : $urandom_range(1, (len > 6) ? 6 : len);
        emit_packet(sb, len, count, 1'b1);
    endtask

    task automatic single_packet();
        logic [7:0] r;
        int         len;
        r = 8'($urandom_range(0, 255));
        body.push_back({r[7], pick_type(chance(45)), r[0]});
        len = chance(2) ? $urandom_range(64, 300) : $urandom_range(1, 12);
        repeat (len - 1) body.push_back(8'($urandom_range(0, 255)));
        emit_packet(unmarked(), 12'(len), len, 1'b1);
    endtask

    task automatic frag_packet();
        logic [7:0] r;
        int         len;
        r = 8'($urandom_range(0, 255));
        body.push_back({r[7], TYPE_FRAG, r[0]});
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back({chance(60) ? 1'b1 : 1'b0, r[6], pick_type(chance(50))});
        len = $urandom_range(1, 10);
        emit_packet(unmarked(), 12'(len), len, 1'b1);
    endtask

    // Aggregation packet: mostly well-formed size-prefixed units, sometimes a bad size.
    task automatic aggr_packet();
        logic [7:0]  r;
        logic [15:0] s;
        int          units;
        r = 8'($urandom_range(0, 255));
        body.push_back({r[7], TYPE_AGGR, r[0]});
        body.push_back(8'($urandom_range(0, 255)));
        units = $urandom_range(1, 3);
        for (int u = 0; u < units; u++) begin
            if (chance(12)) begin
                case ($urandom_range(0, 2))
                    0:       s = 16'd0;
                    1:       s = 16'd1;
                    default: s = 16'($urandom_range(16, 65535));
                endcase
            end else begin
                s = 16'($urandom_range(2, 6));
            end
            body.push_back(s[15:8]);
            body.push_back(s[7:0]);
            if (s < 2 || s > 6) break;
            r = 8'($urandom_range(0, 255));
            body.push_back({r[7], pick_type(chance(40)), r[0]});
            repeat (s - 1) body.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) body.push_back(8'($urandom_range(0, 255)));
        emit_packet(unmarked(), 12'(body.size()), body.size(), 1'b1);
    endtask

    // Malformed traffic: stray items, abandoned packets, early last, extra bytes.
    task automatic noise_packet();
        int len;
        len = $urandom_range(2, 8);
        body.push_back({1'b0, pick_type(chance(50)), 1'b1});
        case ($urandom_range(0, 4))
            0: begin
                body.delete();
                repeat ($urandom_range(1, 2)) offer_item(scrap_item());
            end
            1: emit_packet(unmarked(), 12'(len), $urandom_range(1, len - 1), 1'b0);
            2: emit_packet(unmarked(), 12'(len), $urandom_range(1, len - 1), 1'b1);
            3: emit_packet(unmarked(), 12'(len), len + $urandom_range(1, 3), 1'b1);
            default: begin
                emit_packet(chance(50) ? unmarked() : t_sideband'(8'($urandom_range(0, 255))),
                            12'($urandom_range(0, 8)), $urandom_range(1, 8), 1'b1);
            end
        endcase
    endtask

    // Wait until every owed decision has come back, then let the pipeline settle.
    task automatic drain();
        i_in_valid = 1'b0;
        @(posedge i_clk);
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value on pready.
    task automatic write_target(input logic [2:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_TARGET;
        pwdata  = {29'($urandom_range(0, 32'h1FFF_FFFF)), val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_target(val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Result side: draw a stall stretch, release, take the next decision.
    initial begin
        int       hold;
        t_outcome got;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.fwd     = o_forward;
            got.mk      = o_marker_out;
            got.verdict = t_verdict'(o_verdict);
            got.layer   = o_active_layer_out;
            board.check_result(got);
            @(negedge i_clk);
        end
    end

    // Hard stop in case a handshake hangs.
    initial begin
        #5_000_000;
        $display("FAIL hevc_rtp_temporal_layer_filter_core");
        $finish;
    end

    initial begin
        int phase_start;
        board                 = new();
        items_sent            = 0;
        steady                = 1'b0;
        i_rst_n               = 1'b0;
        i_in_valid            = 1'b0;
        i_data_byte           = '0;
        i_first_of_packet     = 1'b0;
        i_last_of_packet      = 1'b0;
        i_packet_length       = '0;
        i_has_frame_marks     = 1'b0;
        i_mark_start_of_frame = 1'b0;
        i_mark_independent    = 1'b0;
        i_mark_base_sync      = 1'b0;
        i_mark_temporal_id    = '0;
        i_rtp_marker          = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, target at its reset value.
        // Empty packet: judged without any byte.
        emit_packet(unmarked(), 12'd0, 1, 1'b1);
        // Stray item outside a packet: drop silently.
        offer_item(scrap_item());
        // Intra single unit: ends the wait for intra.
        body = '{8'h26, 8'h01, 8'hAB};
        emit_packet(unmarked(), 12'd3, 3, 1'b1);
        // Header too short.
        body = '{8'h02};
        emit_packet(unmarked(), 12'd1, 1, 1'b1);
        // Control unit.
        body = '{8'h46, 8'h01};
        emit_packet(unmarked(), 12'd2, 2, 1'b1);
        // Fragment too short.
        body = '{8'h62, 8'h01};
        emit_packet(unmarked(), 12'd2, 2, 1'b1);
        // Aggregation with a one-byte unit size.
        body = '{8'h60, 8'h01, 8'h00, 8'h01, 8'h26, 8'h00};
        emit_packet(unmarked(), 12'd6, 6, 1'b1);
        // Aggregation with a zero unit size.
        body = '{8'h60, 8'h01, 8'h00, 8'h00, 8'hFF};
        emit_packet(unmarked(), 12'd5, 5, 1'b1);
        // Frame marks at full length and top layer: above a target of zero.
        emit_packet(t_sideband'{1'b1, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1}, 12'd4095, 1, 1'b1);
        // Extra byte past the packet length: ignore it.
        body = '{8'h02, 8'h01, 8'hFF};
        emit_packet(unmarked(), 12'd2, 3, 1'b1);
        // Packet left open: the next first abandons it.
        emit_packet(unmarked(), 12'd4, 1, 1'b0);

        // Random part, one phase per target setting.
        foreach (TARGET_PLAN[p]) begin
            drain();
            write_target(TARGET_PLAN[p]);
            steady      = chance(25);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: marked_packet();
                    7, 8, 9, 10, 11:     single_packet();
                    12, 13, 14, 15:      aggr_packet();
                    16, 17:              frag_packet();
                    default:             noise_packet();
                endcase
                if (chance(5)) steady = !steady;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS hevc_rtp_temporal_layer_filter_core");
        end else begin
            $display("FAIL hevc_rtp_temporal_layer_filter_core");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/hrtf_pkg.sv
sv/hrtf_parse.sv
sv/hevc_rtp_temporal_layer_filter_core.sv
bench/tb_top.sv
